FILE: hw/rtl/ods_pkg.sv
package ods_pkg;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } in_t;

  typedef struct packed {
    logic [31:0] density;
    logic        phase_negative;
  } out_t;

  typedef enum logic [1:0] {
    ORB_1S,
    ORB_2PX,
    ORB_3DXY,
    ORB_4FXYZ
  } orbital_t;

  // series state carried down the exponent pipeline
  typedef struct packed {
    logic [31:0] w;
    logic [32:0] acc;
    logic [7:0]  shift;
    logic [31:0] p;
    logic [31:0] q;
  } poly_t;

  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
  localparam logic [20:0] RECIP3_Q22 = 21'd1398101;
  localparam int          NUM_TERMS  = 10;
  localparam int          DEPTH      = 48;
  localparam logic [7:0]  MAX_SHIFT  = 8'd40;

  // one step of the restoring square root, returns {rem, res}
  function automatic logic [63:0] sqrt_step(logic [31:0] rem, logic [31:0] res,
                                            logic [31:0] bitv);
    logic [32:0] trial;
    logic [31:0] rem_o;
    logic [31:0] res_o;
    trial = {1'b0, res} + {1'b0, bitv};
    if ({1'b0, rem} >= trial) begin
      rem_o = 32'({1'b0, rem} - trial);
      res_o = (res >> 1) + bitv;
    end else begin
      rem_o = rem;
      res_o = res >> 1;
    end
    return {rem_o, res_o};
  endfunction

endpackage

FILE: hw/rtl/orbital_density_sampler.sv
// throughput: one request per cycle; the whole pipeline holds while a result waits under out_stall
// the depth is set by the 16-step square root and the ten-term exponent series
// reset: synchronous active-low rst_n clears all valid bits and selects the 1s orbital
module orbital_density_sampler (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ods_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ods_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_data
);

  ods_pkg::orbital_t orbital_r;
  logic              adv;
  logic              v_r [1:ods_pkg::DEPTH];

  // front end
  logic [30:0]        xx1_r, yy1_r, zz1_r;
  logic signed [31:0] xy1_r;
  logic signed [15:0] x1_r, z1_r;
  logic signed [31:0] sqx, sqy, sqz;
  logic [31:0]        sumsq2_r;
  logic signed [47:0] xyz2_r;
  logic signed [31:0] xy2_r;
  logic signed [15:0] x2_r;

  // shape path
  logic [15:0] ax;
  logic [31:0] axy;
  logic [47:0] axyz;
  logic [31:0] m_nxt, m3_r;
  logic        neg_nxt;
  logic [63:0] mm;
  logic [46:0] sq_r  [4:44];
  logic        neg_r [3:47];

  // square root
  logic [31:0] rem_nxt [0:7];
  logic [31:0] res_nxt [0:7];
  logic [31:0] rem_r   [0:7];
  logic [31:0] res_r   [0:7];

  // exponent argument
  logic [15:0] rad;
  logic [22:0] a11;
  logic [43:0] q3prod;
  logic [22:0] t11_r;
  logic [21:0] q11_r;
  logic [23:0] q3x;
  logic [23:0] q3diff;
  logic [22:0] t12;
  logic [53:0] uprod;
  logic [7:0]  n12_r;
  logic [15:0] f12_r;
  logic [47:0] wprod;
  ods_pkg::poly_t init_r;

  ods_pkg::poly_t ps_nxt [0:ods_pkg::NUM_TERMS-1];
  ods_pkg::poly_t qs_nxt [0:ods_pkg::NUM_TERMS-1];
  ods_pkg::poly_t cs_nxt [0:ods_pkg::NUM_TERMS-1];
  ods_pkg::poly_t ps_r   [0:ods_pkg::NUM_TERMS-1];
  ods_pkg::poly_t qs_r   [0:ods_pkg::NUM_TERMS-1];
  ods_pkg::poly_t cs_r   [0:ods_pkg::NUM_TERMS-1];

  // back end
  ods_pkg::poly_t last;
  logic [32:0] e44_r;
  logic [46:0] hi_prod;
  logic [64:0] lo_prod;
  logic [47:0] hi45_r;
  logic [32:0] lo45_r;
  logic [48:0] d46_r, d47_r;
  logic [57:0] dp47_r;
  logic [31:0] dens_nxt;
  ods_pkg::out_t out_r;

  assign adv       = !v_r[ods_pkg::DEPTH] || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = v_r[ods_pkg::DEPTH];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orbital_r <= ods_pkg::ORB_1S;
    end else if (cfg_valid) begin
      orbital_r <= ods_pkg::orbital_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= ods_pkg::DEPTH; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[1] <= in_valid;
      for (int i = 2; i <= ods_pkg::DEPTH; i++) v_r[i] <= v_r[i-1];
    end
  end

  assign sqx = in_data.coord_x * in_data.coord_x;
  assign sqy = in_data.coord_y * in_data.coord_y;
  assign sqz = in_data.coord_z * in_data.coord_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      xx1_r    <= sqx[30:0];
      yy1_r    <= sqy[30:0];
      zz1_r    <= sqz[30:0];
      xy1_r    <= in_data.coord_x * in_data.coord_y;
      x1_r     <= in_data.coord_x;
      z1_r     <= in_data.coord_z;
      sumsq2_r <= 32'(xx1_r) + 32'(yy1_r) + 32'(zz1_r);
      xyz2_r   <= 48'(xy1_r) * 48'(z1_r);
      xy2_r    <= xy1_r;
      x2_r     <= x1_r;
    end
  end

  // shape magnitude and sign
  assign ax   = x2_r[15] ? 16'(~x2_r + 16'sd1) : 16'(x2_r);
  assign axy  = xy2_r[31] ? 32'(~xy2_r + 32'sd1) : 32'(xy2_r);
  assign axyz = xyz2_r[47] ? 48'(~xyz2_r + 48'sd1) : 48'(xyz2_r);

  always_comb begin
    unique case (orbital_r)
      ods_pkg::ORB_1S: begin
        m_nxt   = 32'h0001_0000;
        neg_nxt = 1'b0;
      end
      ods_pkg::ORB_2PX: begin
        m_nxt   = 32'(ax) << 6;
        neg_nxt = x2_r[15];
      end
      ods_pkg::ORB_3DXY: begin
        m_nxt   = axy >> 4;
        neg_nxt = xy2_r[31];
      end
      default: begin
        m_nxt   = axyz[45:14];
        neg_nxt = xyz2_r[47];
      end
    endcase
  end

  assign mm = 64'(m3_r) * 64'(m3_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_r     <= m_nxt;
      neg_r[3] <= neg_nxt;
      for (int i = 4; i <= 47; i++) neg_r[i] <= neg_r[i-1];
      sq_r[4]  <= mm[62:16];
      for (int i = 5; i <= 44; i++) sq_r[i] <= sq_r[i-1];
    end
  end

  // square root, two result bits per stage
  genvar g;
  generate
    for (g = 0; g < 8; g++) begin : g_sqrt
      localparam logic [31:0] BIT_HI = 32'd1 << (30 - 4*g);
      localparam logic [31:0] BIT_LO = 32'd1 << (28 - 4*g);
      logic [31:0] rem_in, res_in;
      logic [63:0] s_a, s_b;
      if (g == 0) begin : g_first
        assign rem_in = sumsq2_r;
        assign res_in = 32'd0;
      end else begin : g_next
        assign rem_in = rem_r[g-1];
        assign res_in = res_r[g-1];
      end
      assign s_a        = ods_pkg::sqrt_step(rem_in, res_in, BIT_HI);
      assign s_b        = ods_pkg::sqrt_step(s_a[63:32], s_a[31:0], BIT_LO);
      assign rem_nxt[g] = s_b[63:32];
      assign res_nxt[g] = s_b[31:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        rem_r[i] <= rem_nxt[i];
        res_r[i] <= res_nxt[i];
      end
    end
  end

  // exponent argument t, then u = t * log2(e)
  assign rad    = res_r[7][15:0];
  assign a11    = {rad, 7'd0};
  assign q3prod = 44'(a11) * 44'(ods_pkg::RECIP3_Q22);
  assign q3x    = 24'({q11_r, 1'b0}) + 24'(q11_r);
  assign q3diff = 24'(t11_r) - q3x;
  assign t12    = (orbital_r == ods_pkg::ORB_3DXY) ?
                  23'(q11_r) + 23'(q3diff >= 24'd3) : t11_r;
  assign uprod  = 54'(t12) * 54'(ods_pkg::LOG2E_Q30);
  assign wprod  = 48'(f12_r) * 48'(ods_pkg::LN2_Q32);

  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (orbital_r)
        ods_pkg::ORB_1S:    t11_r <= a11;
        ods_pkg::ORB_2PX:   t11_r <= {1'b0, rad, 6'd0};
        ods_pkg::ORB_3DXY:  t11_r <= a11;
        default:            t11_r <= {2'd0, rad, 5'd0};
      endcase
      q11_r        <= q3prod[43:22];
      n12_r        <= uprod[53:46];
      f12_r        <= uprod[45:30];
      init_r.w     <= wprod[47:16];
      init_r.acc   <= 33'h1_0000_0000 - 33'(wprod[47:16]);
      init_r.shift <= n12_r;
      init_r.p     <= wprod[47:16];
      init_r.q     <= 32'd0;
    end
  end

  // series terms for k = 2 .. 11: multiply, reciprocal, correct and accumulate
  genvar j;
  generate
    for (j = 0; j < ods_pkg::NUM_TERMS; j++) begin : g_term
      localparam int          K     = j + 2;
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
      ods_pkg::poly_t src;
      logic [63:0]    pprod;
      logic [63:0]    qprod;
      logic [35:0]    qk;
      logic [35:0]    qdiff;
      logic [31:0]    term;
      if (j == 0) begin : g_first
        assign src = init_r;
      end else begin : g_next
        assign src = cs_r[j-1];
      end
      assign pprod = 64'(src.p) * 64'(src.w);
      assign ps_nxt[j] = '{w: src.w, acc: src.acc, shift: src.shift,
                           p: pprod[63:32], q: src.q};
      assign qprod = 64'(ps_r[j].p) * 64'(RECIP);
      assign qs_nxt[j] = '{w: ps_r[j].w, acc: ps_r[j].acc, shift: ps_r[j].shift,
                           p: ps_r[j].p, q: qprod[63:32]};
      assign qk    = 36'(qs_r[j].q) * 36'(K);
      assign qdiff = 36'(qs_r[j].p) - qk;
      assign term  = qs_r[j].q + 32'(qdiff >= 36'(K));
      assign cs_nxt[j] = '{w: qs_r[j].w,
                           acc: (K % 2 == 1) ? qs_r[j].acc - 33'(term)
                                             : qs_r[j].acc + 33'(term),
                           shift: qs_r[j].shift, p: term, q: qs_r[j].q};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < ods_pkg::NUM_TERMS; i++) begin
        ps_r[i] <= ps_nxt[i];
        qs_r[i] <= qs_nxt[i];
        cs_r[i] <= cs_nxt[i];
      end
    end
  end

  // scale by exp, then by 1/pi where needed
  assign last    = cs_r[ods_pkg::NUM_TERMS-1];
  assign hi_prod = 47'(sq_r[44][46:32]) * 47'(e44_r);
  assign lo_prod = 65'(sq_r[44][31:0]) * 65'(e44_r);

  always_comb begin
    unique case (orbital_r)
      ods_pkg::ORB_1S:   dens_nxt = 32'(dp47_r[57:32]);
      ods_pkg::ORB_2PX:  dens_nxt = 32'(dp47_r[57:37]);
      default:           dens_nxt = (|d47_r[48:32]) ? 32'hFFFF_FFFF : d47_r[31:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e44_r  <= (last.shift >= ods_pkg::MAX_SHIFT) ? 33'd0 : last.acc >> last.shift;
      hi45_r <= 48'(hi_prod);
      lo45_r <= lo_prod[64:32];
      d46_r  <= 49'(hi45_r) + 49'(lo45_r);
      d47_r  <= d46_r;
      dp47_r <= 58'(d46_r[26:0]) * 58'(ods_pkg::INV_PI_Q32);
      out_r.density        <= dens_nxt;
      out_r.phase_negative <= neg_r[47];
    end
  end

endmodule

FILE: hw/rtl/ods_checker.sv
module ods_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input ods_pkg::out_t out_data
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // input backpressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind orbital_density_sampler ods_checker u_ods_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: verif/tb_orbital_density_sampler.sv
module tb_orbital_density_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = ods_pkg::DEPTH;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ods_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ods_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = '0;

  orbital_density_sampler uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  ods_pkg::orbital_t orbital_sel = ods_pkg::ORB_1S;
  ods_pkg::out_t density_queue[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit sender_gaps = 1'b0;
  bit receiver_gaps = 1'b0;
  int hold_off = 0;
  int long_holds = 0;
  int long_holds_seen = 0;

  // exp(-t), t in q.16, result in q.32
  function automatic logic [63:0] decay_q32(logic [63:0] t);
    logic [63:0] u, n, f, w, term;
    logic signed [63:0] acc;
    u = (t * 64'd1549082005) >> 30;
    n = u >> 16;
    f = u & 64'hFFFF;
    w = (f * 64'd2977044472) >> 16;
    term = 64'h1_0000_0000;
    acc = 64'sh1_0000_0000;
    if (n >= 40) return 64'd0;
    for (int k = 1; k <= 11; k++) begin
      term = ((term * w) >> 32) / k;
      if (k % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    return 64'(acc) >> n;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic ods_pkg::out_t orbital_density(ods_pkg::in_t p,
                                                    ods_pkg::orbital_t sel);
    logic signed [63:0] x, y, z, xy, xyz;
    logic [63:0] r, t, m, sq, e, d;
    logic [127:0] wide;
    ods_pkg::out_t o;
    x = p.coord_x;
    y = p.coord_y;
    z = p.coord_z;
    xy = x * y;
    xyz = xy * z;
    r = root_floor(64'(x * x) + 64'(y * y) + 64'(z * z));
    o.phase_negative = 1'b0;
    case (sel)
      ods_pkg::ORB_1S: begin
        t = r << 7;
        m = 64'd1 << 16;
      end
      ods_pkg::ORB_2PX: begin
        t = r << 6;
        m = 64'(x < 0 ? -x : x) << 6;
        o.phase_negative = x < 0;
      end
      ods_pkg::ORB_3DXY: begin
        t = (r << 7) / 3;
        m = 64'(xy < 0 ? -xy : xy) >> 4;
        o.phase_negative = xy < 0;
      end
      default: begin
        t = r << 5;
        m = 64'(xyz < 0 ? -xyz : xyz) >> 14;
        o.phase_negative = xyz < 0;
      end
    endcase
    e = decay_q32(t);
    sq = (m * m) >> 16;
    d = (sq >> 32) * e + (((sq & 64'hFFFF_FFFF) * e) >> 32);
    wide = 128'(d) * 128'd1367130551;
    if (sel == ods_pkg::ORB_1S) d = 64'(wide >> 32);
    else if (sel == ods_pkg::ORB_2PX) d = 64'(wide >> 37);
    o.density = d > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : d[31:0];
    return o;
  endfunction

  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    ods_pkg::in_t p;
    int gap;
    p.coord_x = x;
    p.coord_y = y;
    p.coord_z = z;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    density_queue.push_back(orbital_density(p, orbital_sel));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (density_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic select_orbital(logic [1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    orbital_sel = ods_pkg::orbital_t'(value);
  endtask

  task automatic random_point;
    case ($urandom_range(0, 3))
      0: send_point(16'($urandom), 16'($urandom), 16'($urandom));
      1: send_point(16'($urandom_range(0, 4095) - 2048), 16'($urandom_range(0, 4095) - 2048),
                    16'($urandom_range(0, 4095) - 2048));
      2: send_point(16'($urandom_range(0, 65535) >> $urandom_range(0, 15)),
                    16'($urandom_range(0, 65535) >> $urandom_range(0, 15)),
                    16'($urandom_range(0, 65535) >> $urandom_range(0, 15)));
      default: send_point(16'($urandom_range(0, 16383) - 8192),
                          16'($urandom_range(0, 16383) - 8192),
                          16'($urandom_range(0, 16383) - 8192));
    endcase
  endtask

  task automatic test_directed_points;
    for (int s = 0; s < 4; s++) begin
      select_orbital(2'(s));
      send_point(16'h0000, 16'h0000, 16'h0000);
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_point(16'h8000, 16'h8000, 16'h8000);
      send_point(16'h0400, 16'hFC00, 16'h0400);
      send_point(16'hFC00, 16'h0200, 16'hFE00);
      send_point(16'h0001, 16'hFFFF, 16'h0000);
    end
  endtask

  task automatic test_random_points;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      select_orbital(2'($urandom_range(0, 3)));
      repeat (60) random_point();
    end
  endtask

  task automatic test_backpressure;
    select_orbital(2'($urandom_range(0, 3)));
    long_holds++;
    repeat (100) random_point();
  endtask

  task automatic test_full_rate;
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    for (int s = 3; s >= 0; s--) begin
      select_orbital(2'(s));
      repeat (15) random_point();
    end
  endtask

  always @(posedge clk) begin
    if (long_holds != long_holds_seen) begin
      long_holds_seen <= long_holds;
      out_stall <= 1'b1;
      hold_off <= LONG_HOLD;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (receiver_gaps && !out_stall && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      hold_off <= int'($urandom_range(0, 10));
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    ods_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (density_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = density_queue.pop_front();
        if (out_data.density !== want.density ||
            out_data.phase_negative !== want.phase_negative) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected density %h phase %b, got density %h phase %b",
                     want.density, want.phase_negative, out_data.density,
                     out_data.phase_negative);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_points();
    test_random_points();
    test_backpressure();
    test_full_rate();
    drain();
    if (mismatches == 0 && density_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/ods_pkg.sv
hw/rtl/orbital_density_sampler.sv
hw/rtl/ods_checker.sv
verif/tb_orbital_density_sampler.sv
